// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of the encoder and button block.
// Every assertion is clocked on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define REBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define REBD_NEVER(label, expr, msg) \
    `REBD_ASSERT(label, !(expr), msg)

`endif

// ----- rtl/core/rebd_pkg.sv -----
// Types and constants for the rotary encoder and button event block.
// No dependencies; imported by every module of the block except the checker.
package rebd_pkg;

    // Detent patterns: the last two valid transitions, older one in the high nibble.
    localparam logic [7:0] CW_PATTERN  = 8'h17;
    localparam logic [7:0] CCW_PATTERN = 8'h2B;

    localparam logic        RST_TABLE_MODE   = 1'b1;
    localparam logic [15:0] RST_VALID_MASK   = 16'd27030;
    localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd50;
    localparam logic [15:0] RST_LONG_MS      = 16'd1000;
    localparam logic [15:0] RST_DBL_GAP_MS   = 16'd300;

    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_TABLE_MODE = 3'd0,
        REG_VALID_MASK = 3'd1,
        REG_DEBOUNCE   = 3'd2,
        REG_LONG_CLICK = 3'd3,
        REG_DBL_GAP    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_click_ms;
        logic [15:0] dbl_gap_ms;
    } t_btn_cfg;

    typedef struct packed {
        logic        table_mode;
        logic [15:0] valid_mask;
    } t_rot_cfg;

    typedef struct packed {
        logic step_cw;
        logic step_ccw;
        logic single_click;
        logic long_click;
        logic double_click;
    } t_events;

endpackage

// ----- rtl/core/rebd_button.sv -----
// Push button press classifier: bounce, long, single and double clicks.
// Depends on rebd_pkg for the threshold struct.
module rebd_button
    import rebd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_button_level,
    input  logic [TIME_BITS-1:0] i_time_ms,
    input  t_btn_cfg             i_cfg,
    output logic                 o_single_click,
    output logic                 o_long_click,
    output logic                 o_double_click
);

    logic                 r_button_prev, n_button_prev;
    logic [TIME_BITS-1:0] r_press_time, n_press_time;
    logic [1:0]           r_click_count, n_click_count;
    logic [TIME_BITS-1:0] r_first_click_time, n_first_click_time;

    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] since_first;
    logic [TIME_BITS-1:0] debounce_w, long_w, gap_w;
    logic [1:0]           count_inc;

    // Differences wrap naturally at the register width.
    assign held        = i_time_ms - r_press_time;
    assign since_first = i_time_ms - r_first_click_time;
    assign debounce_w  = TIME_BITS'(i_cfg.debounce_ms);
    assign long_w      = TIME_BITS'(i_cfg.long_click_ms);
    assign gap_w       = TIME_BITS'(i_cfg.dbl_gap_ms);
    assign count_inc   = (r_click_count == 2'd3) ? 2'd3 : r_click_count + 2'd1;

    always_comb begin
        n_button_prev      = i_button_level;
        n_press_time       = r_press_time;
        n_click_count      = r_click_count;
        n_first_click_time = r_first_click_time;
        o_single_click     = 1'b0;
        o_long_click       = 1'b0;
        o_double_click     = 1'b0;
        if (r_button_prev && !i_button_level) begin
            n_press_time = i_time_ms;
        end else if (!r_button_prev && i_button_level) begin
            if (held < debounce_w) begin
                n_click_count = r_click_count;
            end else if (held > long_w) begin
                o_long_click = 1'b1;
            end else begin
                n_click_count = count_inc;
                if (count_inc == 2'd1) begin
                    n_first_click_time = i_time_ms;
                end
            end
        end else begin
            if (r_click_count == 2'd1 && since_first > gap_w) begin
                n_first_click_time = '0;
                n_click_count      = 2'd0;
                o_single_click     = 1'b1;
            end else if (r_click_count > 2'd1) begin
                n_first_click_time = '0;
                n_click_count      = 2'd0;
                o_double_click     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_prev      <= 1'b1;
            r_press_time       <= '0;
            r_click_count      <= 2'd0;
            r_first_click_time <= '0;
        end else if (i_en) begin
            r_button_prev      <= n_button_prev;
            r_press_time       <= n_press_time;
            r_click_count      <= n_click_count;
            r_first_click_time <= n_first_click_time;
        end
    end

endmodule

// ----- rtl/core/rebd_rotary.sv -----
// Quadrature decoder with a transition-table mode and a signal-cleaning mode.
// Depends on rebd_pkg for the detent patterns and the mode struct.
module rebd_rotary
    import rebd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_clk_level,
    input  logic     i_data_level,
    input  t_rot_cfg i_cfg,
    output logic     o_step_cw,
    output logic     o_step_ccw
);

    logic       r_raw_clk_prev, r_raw_data_prev;
    logic       r_clean_clk, r_clean_data, r_clean_clk_prev, r_clean_data_prev;
    logic [3:0] r_pair_history, n_pair_history;
    logic [7:0] r_step_history, n_step_history;
    logic       n_clean_clk, n_clean_data;
    logic       pair_valid;
    logic       tbl_cw, tbl_ccw, cln_cw, cln_ccw;

    // Table mode: only transitions marked in the mask enter the step history.
    assign n_pair_history = {r_pair_history[1:0], i_clk_level, i_data_level};
    assign pair_valid     = i_cfg.valid_mask[n_pair_history];
    assign n_step_history = pair_valid ? {r_step_history[3:0], n_pair_history}
                                       : r_step_history;
    assign tbl_cw  = pair_valid && (n_step_history == CW_PATTERN);
    assign tbl_ccw = pair_valid && (n_step_history == CCW_PATTERN);

    // Cleaning mode: an edge on one pin makes its clean copy take the other pin.
    assign n_clean_clk  = (r_raw_clk_prev != i_clk_level) ? i_data_level : r_clean_clk;
    assign n_clean_data = (r_raw_data_prev != i_data_level) ? i_clk_level : r_clean_data;
    assign cln_cw  = !r_clean_clk_prev && n_clean_clk && !n_clean_data;
    assign cln_ccw = !r_clean_data_prev && n_clean_data && !n_clean_clk;

    assign o_step_cw  = i_cfg.table_mode ? tbl_cw : cln_cw;
    assign o_step_ccw = i_cfg.table_mode ? tbl_ccw : cln_ccw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_clk_prev    <= 1'b1;
            r_raw_data_prev   <= 1'b1;
            r_clean_clk       <= 1'b1;
            r_clean_data      <= 1'b1;
            r_clean_clk_prev  <= 1'b1;
            r_clean_data_prev <= 1'b1;
            r_pair_history    <= 4'd0;
            r_step_history    <= 8'd0;
        end else if (i_en) begin
            if (i_cfg.table_mode) begin
                r_pair_history <= n_pair_history;
                r_step_history <= n_step_history;
            end else begin
                r_raw_clk_prev    <= i_clk_level;
                r_raw_data_prev   <= i_data_level;
                r_clean_clk       <= n_clean_clk;
                r_clean_data      <= n_clean_data;
                r_clean_clk_prev  <= n_clean_clk;
                r_clean_data_prev <= n_clean_data;
            end
        end
    end

endmodule

// ----- rtl/core/rotary_encoder_button_debouncer.sv -----
// Rotary encoder and push button event detector, top level.
// An accepted poll's flags are registered in the output register, or in the skid entry while it waits, before o_valid.
// Throughput: one poll per cycle while o_stall is low; an output register plus a skid entry keep input open.
// o_stall rises only when the skid entry holds a transaction that waits downstream.
// Reset (synchronous, i_rst_n low) clears all decoder state and loads register defaults.
module rotary_encoder_button_debouncer
    import rebd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_clk_level,
    input  logic                 i_data_level,
    input  logic                 i_button_level,
    input  logic [TIME_BITS-1:0] i_time_ms,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_step_cw,
    output logic                 o_step_ccw,
    output logic                 o_single_click,
    output logic                 o_long_click,
    output logic                 o_double_click,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic        r_table_mode;
    logic [15:0] r_valid_mask, r_debounce_ms, r_long_ms, r_dbl_gap_ms;
    t_reg_idx    reg_idx;
    logic        cfg_wr;

    t_btn_cfg btn_cfg;
    t_rot_cfg rot_cfg;
    t_events  events;

    logic    accept, out_take;
    logic    r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    t_events r_out, n_out, r_skid, n_skid;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_mode  <= RST_TABLE_MODE;
            r_valid_mask  <= RST_VALID_MASK;
            r_debounce_ms <= RST_DEBOUNCE_MS;
            r_long_ms     <= RST_LONG_MS;
            r_dbl_gap_ms  <= RST_DBL_GAP_MS;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TABLE_MODE: r_table_mode  <= pwdata[0];
                REG_VALID_MASK: r_valid_mask  <= pwdata[15:0];
                REG_DEBOUNCE:   r_debounce_ms <= pwdata[15:0];
                REG_LONG_CLICK: r_long_ms     <= pwdata[15:0];
                REG_DBL_GAP:    r_dbl_gap_ms  <= pwdata[15:0];
                default:        r_table_mode  <= r_table_mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TABLE_MODE: prdata = {{(DATA_BITS-1){1'b0}}, r_table_mode};
            REG_VALID_MASK: prdata = {{(DATA_BITS-16){1'b0}}, r_valid_mask};
            REG_DEBOUNCE:   prdata = {{(DATA_BITS-16){1'b0}}, r_debounce_ms};
            REG_LONG_CLICK: prdata = {{(DATA_BITS-16){1'b0}}, r_long_ms};
            REG_DBL_GAP:    prdata = {{(DATA_BITS-16){1'b0}}, r_dbl_gap_ms};
            default:        prdata = '0;
        endcase
    end

    assign btn_cfg = '{debounce_ms: r_debounce_ms, long_click_ms: r_long_ms,
                       dbl_gap_ms: r_dbl_gap_ms};
    assign rot_cfg = '{table_mode: r_table_mode, valid_mask: r_valid_mask};

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    rebd_button #(
        .TIME_BITS (TIME_BITS)
    ) u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_button_level (i_button_level),
        .i_time_ms      (i_time_ms),
        .i_cfg          (btn_cfg),
        .o_single_click (events.single_click),
        .o_long_click   (events.long_click),
        .o_double_click (events.double_click)
    );

    rebd_rotary u_rotary (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_clk_level  (i_clk_level),
        .i_data_level (i_data_level),
        .i_cfg        (rot_cfg),
        .o_step_cw    (events.step_cw),
        .o_step_ccw   (events.step_ccw)
    );

    // Output register with one skid entry behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || out_take) begin
                n_out       = events;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = events;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_step_cw      = r_out.step_cw;
    assign o_step_ccw     = r_out.step_ccw;
    assign o_single_click = r_out.single_click;
    assign o_long_click   = r_out.long_click;
    assign o_double_click = r_out.double_click;

endmodule

// ----- rtl/core/rebd_checker.sv -----
// Port-level checker for the encoder and button event block, bound to the top level.
// Depends on assert_macros.svh only.
`include "assert_macros.svh"

module rebd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_step_cw,
    input logic o_step_ccw,
    input logic o_single_click,
    input logic o_long_click,
    input logic o_double_click
);

    logic [2:0] click_kinds;

    assign click_kinds = {o_single_click, o_long_click, o_double_click};

    // A result that is held back stays offered.
    `REBD_ASSERT(a_valid_holds, o_valid && i_stall |=> o_valid, "result dropped under stall")

    // One poll can never turn the knob both ways.
    `REBD_NEVER(a_step_excl, o_valid && o_step_cw && o_step_ccw, "both step directions")

    // A poll reports at most one kind of click.
    `REBD_ASSERT(a_click_excl, o_valid |-> $onehot0(click_kinds), "more than one click kind")

    // The input side only backs up when a result waited downstream the cycle before.
    `REBD_ASSERT(a_stall_cause, $rose(o_stall) |-> $past(o_valid && i_stall), "stray stall")

endmodule

bind rotary_encoder_button_debouncer rebd_checker u_rebd_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the rotary encoder and button event block.
// Depends on rtl/core/rebd_pkg.sv and the block's top level with the modules under it.
// It predicts the event flags of every poll and checks them against the block's output.
module tb_top;
    import rebd_pkg::*;

    localparam logic [ADDR_BITS-1:0] ADDR_TABLE_MODE = {REG_TABLE_MODE, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_VALID_MASK = {REG_VALID_MASK, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_DEBOUNCE   = {REG_DEBOUNCE, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_LONG_CLICK = {REG_LONG_CLICK, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_DBL_GAP    = {REG_DBL_GAP, 2'b00};
    localparam logic [ADDR_BITS-1:0] ADDR_UNMAPPED   = 5'd28;

    // Quadrature walk in the clockwise direction, position 0 in the low bits.
    localparam logic [7:0] GRAY_WALK = 8'b10_11_01_00;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_clk_level;
    logic                 i_data_level;
    logic                 i_button_level;
    logic [31:0]          i_time_ms;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_step_cw;
    logic                 o_step_ccw;
    logic                 o_single_click;
    logic                 o_long_click;
    logic                 o_double_click;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    rotary_encoder_button_debouncer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_clk_level    (i_clk_level),
        .i_data_level   (i_data_level),
        .i_button_level (i_button_level),
        .i_time_ms      (i_time_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_step_cw      (o_step_cw),
        .o_step_ccw     (o_step_ccw),
        .o_single_click (o_single_click),
        .o_long_click   (o_long_click),
        .o_double_click (o_double_click),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Register copies kept by the predictor.
    logic        cfg_table_mode = RST_TABLE_MODE;
    logic [15:0] cfg_valid_mask = RST_VALID_MASK;
    logic [15:0] cfg_debounce   = RST_DEBOUNCE_MS;
    logic [15:0] cfg_long       = RST_LONG_MS;
    logic [15:0] cfg_gap        = RST_DBL_GAP_MS;

    // Decoder state of the predictor, at its reset values.
    logic        raw_clk_seen      = 1'b1;
    logic        raw_dat_seen      = 1'b1;
    logic        clk_filtered      = 1'b1;
    logic        dat_filtered      = 1'b1;
    logic        clk_filtered_last = 1'b1;
    logic        dat_filtered_last = 1'b1;
    logic [3:0]  pair_idx          = 4'd0;
    logic [7:0]  detent_hist       = 8'd0;
    logic        btn_last          = 1'b1;
    logic [31:0] press_start       = 32'd0;
    logic [1:0]  clicks            = 2'd0;
    logic [31:0] click_start       = 32'd0;

    t_events     exp_events[$];
    int          fail_count = 0;
    int          polls_sent = 0;
    bit          idle_on    = 1'b1;
    logic [31:0] now_ms     = 32'd0;
    logic [1:0]  enc_pos    = 2'd0;
    logic [1:0]  enc_dir    = 2'd1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2400000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_events predict_poll(input logic c, input logic d, input logic b,
                                             input logic [31:0] now);
        t_events     ev;
        logic [31:0] held;
        logic [31:0] since_click;
        ev = '0;
        held = now - press_start;
        since_click = now - click_start;
        if (btn_last && !b) begin
            press_start = now;
        end else if (!btn_last && b) begin
            if (held >= cfg_debounce) begin
                if (held > cfg_long) begin
                    ev.long_click = 1'b1;
                end else begin
                    if (clicks != 2'd3) clicks = clicks + 2'd1;
                    if (clicks == 2'd1) click_start = now;
                end
            end
        end else if (clicks == 2'd1 && since_click > cfg_gap) begin
            click_start = '0;
            clicks = '0;
            ev.single_click = 1'b1;
        end else if (clicks > 2'd1) begin
            click_start = '0;
            clicks = '0;
            ev.double_click = 1'b1;
        end
        btn_last = b;

        if (cfg_table_mode) begin
            pair_idx = {pair_idx[1:0], c, d};
            if (cfg_valid_mask[pair_idx]) begin
                detent_hist = {detent_hist[3:0], pair_idx};
                ev.step_cw  = (detent_hist == CW_PATTERN);
                ev.step_ccw = (detent_hist == CCW_PATTERN);
            end
        end else begin
            // An edge on one raw line latches the level of the other line.
            if (raw_clk_seen != c) begin
                raw_clk_seen = c;
                clk_filtered = d;
            end
            if (raw_dat_seen != d) begin
                raw_dat_seen = d;
                dat_filtered = c;
            end
            ev.step_cw  = !clk_filtered_last && clk_filtered && !dat_filtered;
            ev.step_ccw = !dat_filtered_last && dat_filtered && !clk_filtered;
            clk_filtered_last = clk_filtered;
            dat_filtered_last = dat_filtered;
        end
        return ev;
    endfunction

    task automatic check_flag(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_events want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_events.size() == 0) begin
                $error("result transaction arrived with no poll outstanding");
                fail_count++;
            end else begin
                want = exp_events.pop_front();
                check_flag("step_cw", want.step_cw, o_step_cw);
                check_flag("step_ccw", want.step_ccw, o_step_ccw);
                check_flag("single_click", want.single_click, o_single_click);
                check_flag("long_click", want.long_click, o_long_click);
                check_flag("double_click", want.double_click, o_double_click);
            end
        end
    end

    // Receiver side: random stall bursts while idling is enabled.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && i_rst_n && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_poll(input logic c, input logic d, input logic b,
                             input logic [31:0] t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_clk_level    <= c;
        i_data_level   <= d;
        i_button_level <= b;
        i_time_ms      <= t;
        do @(posedge i_clk); while (o_stall);
        exp_events.push_back(predict_poll(c, d, b, t));
        polls_sent++;
    endtask

    // Advances time and the encoder; with jitter the encoder also reverses, rests or glitches.
    task automatic poll(input logic b, input logic [31:0] dt, input bit jitter);
        int unsigned r;
        logic [1:0]  lv;
        r = jitter ? $urandom_range(0, 19) : 0;
        if (r == 12 || r == 13) enc_dir = -enc_dir;
        if (r <= 13) enc_pos = enc_pos + enc_dir;
        lv = (r >= 17) ? 2'($urandom) : GRAY_WALK[2*enc_pos +: 2];
        now_ms = now_ms + dt;
        send_poll(lv[1], lv[0], b, now_ms);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (exp_events.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_TABLE_MODE: cfg_table_mode = value[0];
            ADDR_VALID_MASK: cfg_valid_mask = value[15:0];
            ADDR_DEBOUNCE:   cfg_debounce   = value[15:0];
            ADDR_LONG_CLICK: cfg_long       = value[15:0];
            ADDR_DBL_GAP:    cfg_gap        = value[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic tm, input logic [15:0] mask, input logic [15:0] deb,
                           input logic [15:0] lng, input logic [15:0] gap);
        cfg_write(ADDR_TABLE_MODE, {31'd0, tm});
        cfg_write(ADDR_VALID_MASK, {16'd0, mask});
        cfg_write(ADDR_DEBOUNCE, {16'd0, deb});
        cfg_write(ADDR_LONG_CLICK, {16'd0, lng});
        cfg_write(ADDR_DBL_GAP, {16'd0, gap});
    endtask

    task automatic press_hold(input int unsigned held);
        int unsigned k;
        int unsigned part;
        k = $urandom_range(0, 3);
        part = held / (k + 1);
        poll(1'b0, $urandom_range(0, 40), 1'b1);
        repeat (k) poll(1'b0, part, 1'b1);
        poll(1'b1, held - k * part, 1'b1);
    endtask

    // Mostly complete button gestures around the current thresholds, with some noise.
    task automatic random_gestures(input int count);
        int start;
        start = polls_sent;
        while (polls_sent - start < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: press_hold($urandom_range(cfg_debounce, cfg_long));
                3: begin
                    press_hold($urandom_range(cfg_debounce, cfg_long));
                    poll(1'b1, $urandom_range(0, cfg_gap), 1'b1);
                    press_hold($urandom_range(cfg_debounce, cfg_long));
                end
                4: press_hold(cfg_long + $urandom_range(1, 3000));
                5: press_hold(cfg_debounce == 0 ? 0 : $urandom_range(0, cfg_debounce - 1));
                6: repeat ($urandom_range(1, 4))
                    poll(1'b1, $urandom_range(0, 2 * cfg_gap + 20), 1'b1);
                7: begin
                    repeat ($urandom_range(1, 6))
                        poll($urandom_range(0, 1), $urandom_range(0, 120), 1'b1);
                    poll(1'b1, $urandom_range(0, 120), 1'b1);
                end
                8: poll(1'b1, $urandom, 1'b1);
                default: begin
                    // Presses that land exactly on or next to a threshold.
                    case ($urandom_range(0, 3))
                        0: press_hold(cfg_debounce == 0 ? 0 : cfg_debounce - 1);
                        1: press_hold(cfg_debounce);
                        2: press_hold(cfg_long);
                        default: press_hold(cfg_long + 1);
                    endcase
                end
            endcase
        end
    endtask

    task automatic test_table_detents();
        send_poll(1'b0, 1'b0, 1'b1, 32'd0);
        send_poll(1'b0, 1'b1, 1'b1, 32'd1);
        send_poll(1'b1, 1'b1, 1'b1, 32'd2);
        send_poll(1'b0, 1'b0, 1'b1, 32'd3);
        send_poll(1'b1, 1'b0, 1'b1, 32'd4);
        send_poll(1'b1, 1'b1, 1'b1, 32'd5);
    endtask

    task automatic test_button_events();
        cfg_write(ADDR_TABLE_MODE, 32'd0);
        enc_pos = 2'd2;
        enc_dir = 2'd1;
        // The bounce press starts at the top of the time range and wraps on release.
        now_ms = 32'hFFFF_FFCF;
        poll(1'b0, 48, 1'b0);
        poll(1'b1, 49, 1'b0);
        poll(1'b0, 10, 1'b0);
        poll(1'b1, 1001, 1'b0);
        poll(1'b0, 5, 1'b0);
        poll(1'b1, 50, 1'b0);
        poll(1'b1, 301, 1'b0);
        enc_dir = 2'd3;
        poll(1'b0, 5, 1'b0);
        poll(1'b1, 1000, 1'b0);
        poll(1'b0, 100, 1'b0);
        poll(1'b1, 60, 1'b0);
        poll(1'b1, 1, 1'b0);
        // Three clicks back to back saturate the click count.
        repeat (3) begin
            poll(1'b0, 5, 1'b0);
            poll(1'b1, 70, 1'b0);
        end
        poll(1'b1, 1, 1'b0);
    endtask

    task automatic test_register_extremes();
        cfg_write(ADDR_VALID_MASK, 32'hFFFF_FFFF);
        cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        cfg_all(1'b1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        random_gestures(150);
        cfg_all(1'b1, 16'h0000, 16'hFFFF, 16'd0, 16'hFFFF);
        random_gestures(150);
    endtask

    task automatic test_cleaning_random();
        cfg_all(1'b0, 16'($urandom), 16'd10, 16'd200, 16'd80);
        random_gestures(200);
    endtask

    task automatic test_default_random();
        cfg_all(RST_TABLE_MODE, RST_VALID_MASK, RST_DEBOUNCE_MS, RST_LONG_MS, RST_DBL_GAP_MS);
        random_gestures(275);
    endtask

    task automatic test_steady_stream();
        cfg_all(1'b1, 16'($urandom) | RST_VALID_MASK, 16'd20, 16'd400, 16'd150);
        idle_on = 1'b0;
        random_gestures(150);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_clk_level    = 1'b1;
        i_data_level   = 1'b1;
        i_button_level = 1'b1;
        i_time_ms      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_detents();
        test_button_events();
        test_register_extremes();
        test_cleaning_random();
        test_default_random();
        test_steady_stream();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rebd_pkg.sv
rtl/core/rebd_button.sv
rtl/core/rebd_rotary.sv
rtl/core/rotary_encoder_button_debouncer.sv
rtl/core/rebd_checker.sv
verif/tb_top.sv
